/* rtl/mask_row_boundary_extractor_assert.svh */
// Assertion macros for the mask row boundary extractor.
`ifndef MASK_ROW_BOUNDARY_EXTRACTOR_ASSERT_SVH
`define MASK_ROW_BOUNDARY_EXTRACTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define MRBE_ASSERT_IMPL(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mrbe: same-cycle check failed");
`define MRBE_ASSERT_NEXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mrbe: next-cycle check failed");
`else
`define MRBE_ASSERT_IMPL(name, clk, rstn, ante, cons)
`define MRBE_ASSERT_NEXT(name, clk, rstn, ante, cons)
`endif
`endif

/* rtl/mrbe_pkg.sv */
// Shared types and constants of the mask row boundary extractor.
`default_nettype none
package mrbe_pkg;

  localparam int ROW_W     = 8;
  localparam int COL_W     = 8;
  localparam int CFG_W     = 13;
  localparam int COORD_W   = 20;
  localparam int CFG_IDX_W = 1;
  localparam int TAG_W     = 2;

  localparam int MRBE_MASK_SIZE  = 256;
  localparam int MRBE_ROW_STRIDE = 8;

  localparam logic [COORD_W-1:0] COORD_MAX   = 20'd1044480;
  localparam logic [CFG_W-1:0]   FRAME_W_RST = 13'd1280;
  localparam logic [CFG_W-1:0]   FRAME_H_RST = 13'd720;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 1'd1;

  // input item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_EOF   = 1'b1;

  // scaler tags, one per coordinate of a segment
  localparam logic [TAG_W-1:0] TAG_SX = 2'd0;
  localparam logic [TAG_W-1:0] TAG_SY = 2'd1;
  localparam logic [TAG_W-1:0] TAG_EX = 2'd2;
  localparam logic [TAG_W-1:0] TAG_EY = 2'd3;

  typedef struct packed {
    logic act;
    logic clr;
  } scan_ctl_t;

  typedef struct packed {
    logic             point;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
  } scan_rsp_t;

  typedef struct packed {
    logic             vld;
    logic             is_y;
    logic [TAG_W-1:0] tag;
  } sc_req_t;

  typedef struct packed {
    logic               vld;
    logic [TAG_W-1:0]   tag;
    logic [COORD_W-1:0] value;
  } sc_res_t;

endpackage
`default_nettype wire

/* rtl/mrbe_if.sv */
// Channel interfaces of the mask row boundary extractor.
`default_nettype none
interface mrbe_in_if import mrbe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [ROW_W-1:0] row;
  logic [COL_W-1:0] column;
  logic             drivable;

  modport source (output valid, kind, row, column, drivable, input ready);
  modport sink (input valid, kind, row, column, drivable, output ready);
endinterface

interface mrbe_out_if import mrbe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] start_x;
  logic [COORD_W-1:0] start_y;
  logic [COORD_W-1:0] end_x;
  logic [COORD_W-1:0] end_y;
  logic               side;
  logic               last_segment;

  modport source (output valid, start_x, start_y, end_x, end_y, side, last_segment,
                  input ready);
  modport sink (input valid, start_x, start_y, end_x, end_y, side, last_segment,
                output ready);
endinterface

interface mrbe_cfg_if import mrbe_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/mrbe_store.sv */
// Per-row column store: read-modify-write of left/right columns with forwarding.
`default_nettype none
module mrbe_store import mrbe_pkg::*; #(
  parameter int MASK_SIZE  = MRBE_MASK_SIZE,
  parameter int ROW_STRIDE = MRBE_ROW_STRIDE,
  localparam int TOP_ROW = MASK_SIZE / 4,
  localparam int NS      = ((MASK_SIZE - 1 - TOP_ROW) / ROW_STRIDE) + 1,
  localparam int K_W     = (NS > 1) ? $clog2(NS) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             pix_go,
  input  wire logic [ROW_W-1:0] pix_row,
  input  wire logic [COL_W-1:0] pix_col,
  input  wire scan_ctl_t        scan_ctl,
  input  wire logic [K_W-1:0]   scan_idx,
  output scan_rsp_t             scan_rsp
);

  localparam int ROWS = 1 << ROW_W;
  localparam int ENT_W = 2 * COL_W;
  localparam logic [ENT_W-1:0] EMPTY_ENT = {{COL_W{1'b1}}, {COL_W{1'b0}}};

  logic           row_hit [ROWS];
  logic [K_W-1:0] row_k   [ROWS];

  // row -> sample slot lookup, built at elaboration
  for (genvar r = 0; r < ROWS; r++) begin : g_row
    localparam int DIST = MASK_SIZE - 1 - r;
    localparam bit HIT = (DIST >= 0) && (r >= TOP_ROW) && ((DIST % ROW_STRIDE) == 0) &&
                         ((DIST / ROW_STRIDE) < NS);
    localparam int KI = HIT ? (DIST / ROW_STRIDE) : 0;
    assign row_hit[r] = HIT;
    assign row_k[r]   = K_W'(KI);
  end

  logic [ENT_W-1:0] mem [NS];
  logic [ENT_W-1:0] rd_data_r;
  logic [NS-1:0]    seen_r;
  logic             s1_vld_r;
  logic [K_W-1:0]   s1_k_r;
  logic [COL_W-1:0] s1_col_r;
  logic             wr_vld_r;
  logic [K_W-1:0]   wr_addr_r;
  logic [ENT_W-1:0] wr_data_r;

  logic             pix_hit;
  logic [K_W-1:0]   rd_addr;
  logic [ENT_W-1:0] old_ent;
  logic [COL_W-1:0] old_l;
  logic [COL_W-1:0] old_r;
  logic [ENT_W-1:0] new_ent;

  assign pix_hit = pix_go && row_hit[pix_row] && (32'(pix_col) < MASK_SIZE);
  assign rd_addr = scan_ctl.act ? scan_idx : row_k[pix_row];

  // forward the write of the previous cycle, which the memory read missed
  always_comb begin
    if (wr_vld_r && (wr_addr_r == s1_k_r)) begin
      old_ent = wr_data_r;
    end else if (seen_r[s1_k_r]) begin
      old_ent = rd_data_r;
    end else begin
      old_ent = EMPTY_ENT;
    end
    old_l = old_ent[ENT_W-1:COL_W];
    old_r = old_ent[COL_W-1:0];
    new_ent[ENT_W-1:COL_W] = (s1_col_r < old_l) ? s1_col_r : old_l;
    new_ent[COL_W-1:0]     = (s1_col_r > old_r) ? s1_col_r : old_r;
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
    if (s1_vld_r) begin
      mem[s1_k_r] <= new_ent;
    end
  end

  always_ff @(posedge clk) begin
    s1_k_r    <= row_k[pix_row];
    s1_col_r  <= pix_col;
    wr_addr_r <= s1_k_r;
    wr_data_r <= new_ent;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      wr_vld_r <= 1'b0;
      seen_r   <= '0;
    end else begin
      s1_vld_r <= pix_hit;
      wr_vld_r <= s1_vld_r;
      if (scan_ctl.clr) begin
        seen_r <= '0;
      end else if (s1_vld_r) begin
        seen_r[s1_k_r] <= 1'b1;
      end
    end
  end

  always_comb begin
    scan_rsp.left  = rd_data_r[ENT_W-1:COL_W];
    scan_rsp.right = rd_data_r[COL_W-1:0];
    scan_rsp.point = seen_r[scan_idx] && (rd_data_r[COL_W-1:0] > rd_data_r[ENT_W-1:COL_W]);
  end

endmodule
`default_nettype wire

/* rtl/mrbe_scaler.sv */
// Three-stage coordinate scaler: pos * size * 256 / MASK_SIZE, saturated.
`default_nettype none
module mrbe_scaler import mrbe_pkg::*; #(
  parameter int MASK_SIZE = MRBE_MASK_SIZE,
  parameter int POS_W     = COL_W
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire sc_req_t          req,
  input  wire logic [POS_W-1:0] pos,
  input  wire logic [CFG_W-1:0] frame_w,
  input  wire logic [CFG_W-1:0] frame_h,
  output sc_res_t               res
);

  localparam int P_W  = POS_W + CFG_W;
  localparam int N    = P_W + 8;
  localparam int L    = $clog2(MASK_SIZE);
  localparam int SH   = N + L;
  localparam int M_W  = N + 1;
  localparam int PR_W = N + M_W;
  localparam int Q_W  = PR_W - SH;
  // exact reciprocal: floor(x * RECIP >> SH) == floor(x / MASK_SIZE) for x < 2**N
  localparam logic [63:0]    RECIP_64 = ((64'd1 << SH) + 64'(MASK_SIZE) - 64'd1) /
                                        64'(MASK_SIZE);
  localparam logic [M_W-1:0] RECIP    = M_W'(RECIP_64);

  logic [P_W-1:0]   p_r;
  logic [PR_W-1:0]  prod_r;
  logic [COORD_W-1:0] val_r;
  logic             v1_r, v2_r, v3_r;
  logic [TAG_W-1:0] t1_r, t2_r, t3_r;
  logic [Q_W-1:0]   q;
  logic [N-1:0]     x;

  assign x = {p_r, 8'b0};
  assign q = prod_r[PR_W-1:SH];

  always_ff @(posedge clk) begin
    p_r    <= P_W'(pos) * P_W'(req.is_y ? frame_h : frame_w);
    prod_r <= PR_W'(x) * PR_W'(RECIP);
    val_r  <= (q > Q_W'(COORD_MAX)) ? COORD_MAX : q[COORD_W-1:0];
    t1_r   <= req.tag;
    t2_r   <= t1_r;
    t3_r   <= t2_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= req.vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign res.vld   = v3_r;
  assign res.tag   = t3_r;
  assign res.value = val_r;

endmodule
`default_nettype wire

/* rtl/mrbe_seq.sv */
// Frame-end sequencer: walks the store for left segments, then right if 2+ points.
`default_nettype none
module mrbe_seq import mrbe_pkg::*; #(
  parameter int MASK_SIZE  = MRBE_MASK_SIZE,
  parameter int ROW_STRIDE = MRBE_ROW_STRIDE,
  localparam int TOP_ROW = MASK_SIZE / 4,
  localparam int NS      = ((MASK_SIZE - 1 - TOP_ROW) / ROW_STRIDE) + 1,
  localparam int K_W     = (NS > 1) ? $clog2(NS) : 1,
  localparam int POS_W   = ($clog2(MASK_SIZE) > COL_W) ? $clog2(MASK_SIZE) : COL_W
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       eof_go,
  output logic            busy,
  output scan_ctl_t       scan_ctl,
  output logic [K_W-1:0]  scan_idx,
  input  wire scan_rsp_t  scan_rsp,
  output sc_req_t         sc_req,
  output logic [POS_W-1:0] sc_pos,
  input  wire sc_res_t    sc_res,
  mrbe_out_if.source      out_ch
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_RD    = 3'd1;
  localparam logic [2:0] S_CHK   = 3'd2;
  localparam logic [2:0] S_ISSUE = 3'd3;
  localparam logic [2:0] S_WAIT  = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;
  localparam logic [2:0] S_ADV   = 3'd6;

  localparam logic [POS_W-1:0] MAX_ROW = POS_W'(MASK_SIZE - 1);
  localparam logic [POS_W-1:0] STRIDE  = POS_W'(ROW_STRIDE);
  localparam logic [K_W-1:0]   LAST_K  = K_W'(NS - 1);

  logic [2:0]       state_r, state_nxt;
  logic [K_W-1:0]   k_r, k_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic             pass_r, pass_nxt;
  logic             have_prev_r, have_prev_nxt;
  logic [1:0]       cnt_r, cnt_nxt;
  logic [K_W-1:0]   klast_r, klast_nxt;
  logic [COL_W-1:0] prev_col_r, prev_col_nxt;
  logic [POS_W-1:0] prev_row_r, prev_row_nxt;
  logic [COL_W-1:0] cur_col_r, cur_col_nxt;
  logic [TAG_W-1:0] iss_r, iss_nxt;
  logic             last_r, last_nxt;
  logic [COORD_W-1:0] sx_r, sy_r, ex_r, ey_r;
  logic [COL_W-1:0] pt_col;

  assign pt_col = pass_r ? scan_rsp.right : scan_rsp.left;

  always_comb begin
    state_nxt     = state_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    pass_nxt      = pass_r;
    have_prev_nxt = have_prev_r;
    cnt_nxt       = cnt_r;
    klast_nxt     = klast_r;
    prev_col_nxt  = prev_col_r;
    prev_row_nxt  = prev_row_r;
    cur_col_nxt   = cur_col_r;
    iss_nxt       = iss_r;
    last_nxt      = last_r;
    scan_ctl.act  = busy;
    scan_ctl.clr  = 1'b0;
    sc_req.vld    = 1'b0;
    sc_req.tag    = iss_r;
    sc_req.is_y   = iss_r[0];
    case (state_r)
      S_IDLE: begin
        if (eof_go) begin
          k_nxt         = '0;
          row_nxt       = MAX_ROW;
          pass_nxt      = 1'b0;
          have_prev_nxt = 1'b0;
          cnt_nxt       = 2'd0;
          state_nxt     = S_RD;
        end
      end
      S_RD: state_nxt = S_CHK;
      S_CHK: begin
        state_nxt = S_ADV;
        if (scan_rsp.point) begin
          cur_col_nxt = pt_col;
          if (!pass_r) begin
            klast_nxt = k_r;
            if (cnt_r != 2'd2) begin
              cnt_nxt = cnt_r + 2'd1;
            end
          end
          if (have_prev_r) begin
            iss_nxt   = TAG_SX;
            last_nxt  = pass_r && (k_r == klast_r);
            state_nxt = S_ISSUE;
          end else begin
            prev_col_nxt  = pt_col;
            prev_row_nxt  = row_r;
            have_prev_nxt = 1'b1;
          end
        end
      end
      S_ISSUE: begin
        sc_req.vld = 1'b1;
        iss_nxt    = iss_r + 2'd1;
        if (iss_r == TAG_EY) begin
          // this point becomes the start of the next segment
          prev_col_nxt = cur_col_r;
          prev_row_nxt = row_r;
          state_nxt    = S_WAIT;
        end
      end
      S_WAIT: begin
        if (sc_res.vld && (sc_res.tag == TAG_EY)) begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_ADV;
        end
      end
      S_ADV: begin
        if (k_r == LAST_K) begin
          if (!pass_r && (cnt_r == 2'd2)) begin
            pass_nxt      = 1'b1;
            k_nxt         = '0;
            row_nxt       = MAX_ROW;
            have_prev_nxt = 1'b0;
            state_nxt     = S_RD;
          end else begin
            scan_ctl.clr = 1'b1;
            state_nxt    = S_IDLE;
          end
        end else begin
          k_nxt     = k_r + K_W'(1);
          row_nxt   = row_r - STRIDE;
          state_nxt = S_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // issue mux: start point from prev, end point from the current row
  always_comb begin
    case (iss_r)
      TAG_SX:  sc_pos = POS_W'(prev_col_r);
      TAG_SY:  sc_pos = prev_row_r;
      TAG_EX:  sc_pos = POS_W'(cur_col_r);
      TAG_EY:  sc_pos = row_r;
      default: sc_pos = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      k_r         <= '0;
      row_r       <= MAX_ROW;
      pass_r      <= 1'b0;
      have_prev_r <= 1'b0;
      cnt_r       <= 2'd0;
      klast_r     <= '0;
      iss_r       <= TAG_SX;
      last_r      <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      k_r         <= k_nxt;
      row_r       <= row_nxt;
      pass_r      <= pass_nxt;
      have_prev_r <= have_prev_nxt;
      cnt_r       <= cnt_nxt;
      klast_r     <= klast_nxt;
      iss_r       <= iss_nxt;
      last_r      <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_col_r <= prev_col_nxt;
    prev_row_r <= prev_row_nxt;
    cur_col_r  <= cur_col_nxt;
    if (sc_res.vld) begin
      case (sc_res.tag)
        TAG_SX:  sx_r <= sc_res.value;
        TAG_SY:  sy_r <= sc_res.value;
        TAG_EX:  ex_r <= sc_res.value;
        TAG_EY:  ey_r <= sc_res.value;
        default: ;
      endcase
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign scan_idx = k_r;

  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.start_x      = sx_r;
  assign out_ch.start_y      = sy_r;
  assign out_ch.end_x        = ex_r;
  assign out_ch.end_y        = ey_r;
  assign out_ch.side         = pass_r;
  assign out_ch.last_segment = last_r;

endmodule
`default_nettype wire

/* rtl/mask_row_boundary_extractor.sv */
// Mask pixels are taken one per cycle while the block is idle; each pixel on a
// sampled row is folded into a one-port-read, one-port-write column memory with
// a registered read-modify-write and forwarding, so back-to-back pixels to the
// same row are safe. An end-of-frame transaction takes the block busy: the
// sequencer walks all NS sampled rows (NS = 24 at the defaults) for the left
// edge, and again for the right edge when there are two or more points; each
// row steps through read, check and advance states. For each emitted segment it
// issues the four coordinates into the shared three-stage scaler, waits for the
// last result, then offers the output transaction, which may stall. No pixel is
// taken until the walk ends and the row valid bits are cleared.
`default_nettype none
`include "mask_row_boundary_extractor_assert.svh"
module mask_row_boundary_extractor import mrbe_pkg::*; #(
  parameter int MASK_SIZE  = MRBE_MASK_SIZE,
  parameter int ROW_STRIDE = MRBE_ROW_STRIDE
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mrbe_in_if.sink    in_ch,
  mrbe_out_if.source out_ch,
  mrbe_cfg_if.sink   cfg_ch
);

  localparam int TOP_ROW = MASK_SIZE / 4;
  localparam int NS      = ((MASK_SIZE - 1 - TOP_ROW) / ROW_STRIDE) + 1;
  localparam int K_W     = (NS > 1) ? $clog2(NS) : 1;
  localparam int POS_W   = ($clog2(MASK_SIZE) > COL_W) ? $clog2(MASK_SIZE) : COL_W;

  logic [CFG_W-1:0] frame_w_r;
  logic [CFG_W-1:0] frame_h_r;
  logic             busy;
  logic             pix_go;
  logic             eof_go;
  scan_ctl_t        scan_ctl;
  scan_rsp_t        scan_rsp;
  logic [K_W-1:0]   scan_idx;
  sc_req_t          sc_req;
  sc_res_t          sc_res;
  logic [POS_W-1:0] sc_pos;

  assign in_ch.ready  = !busy;
  assign cfg_ch.ready = 1'b1;
  assign pix_go = in_ch.valid && in_ch.ready && (in_ch.kind == KIND_PIXEL) &&
                  in_ch.drivable;
  assign eof_go = in_ch.valid && in_ch.ready && (in_ch.kind == KIND_EOF);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_w_r <= FRAME_W_RST;
      frame_h_r <= FRAME_H_RST;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_FRAME_WIDTH:  frame_w_r <= cfg_ch.data;
        CFG_FRAME_HEIGHT: frame_h_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  mrbe_store #(
    .MASK_SIZE  (MASK_SIZE),
    .ROW_STRIDE (ROW_STRIDE)
  ) u_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .pix_go   (pix_go),
    .pix_row  (in_ch.row),
    .pix_col  (in_ch.column),
    .scan_ctl (scan_ctl),
    .scan_idx (scan_idx),
    .scan_rsp (scan_rsp)
  );

  mrbe_scaler #(
    .MASK_SIZE (MASK_SIZE),
    .POS_W     (POS_W)
  ) u_scaler (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (sc_req),
    .pos     (sc_pos),
    .frame_w (frame_w_r),
    .frame_h (frame_h_r),
    .res     (sc_res)
  );

  mrbe_seq #(
    .MASK_SIZE  (MASK_SIZE),
    .ROW_STRIDE (ROW_STRIDE)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .eof_go   (eof_go),
    .busy     (busy),
    .scan_ctl (scan_ctl),
    .scan_idx (scan_idx),
    .scan_rsp (scan_rsp),
    .sc_req   (sc_req),
    .sc_pos   (sc_pos),
    .sc_res   (sc_res),
    .out_ch   (out_ch)
  );

  `MRBE_ASSERT_IMPL(a_no_take_while_emit, clk, rst_n, out_ch.valid, !in_ch.ready)
  `MRBE_ASSERT_IMPL(a_last_is_right, clk, rst_n, out_ch.valid && out_ch.last_segment, out_ch.side)
  `MRBE_ASSERT_NEXT(a_eof_goes_busy, clk, rst_n, eof_go, busy)
  `MRBE_ASSERT_IMPL(a_scaler_idle_when_free, clk, rst_n, !busy, !sc_req.vld)

endmodule
`default_nettype wire

/* bench/mask_row_boundary_extractor_tb.sv */
// Self-checking testbench for the mask row boundary extractor: random frames, scaled segments.
module mask_row_boundary_extractor_tb;
  import mrbe_pkg::*;

  localparam int TOP_ROW        = MRBE_MASK_SIZE / 4;
  localparam int NUM_ROWS       = ((MRBE_MASK_SIZE - 1 - TOP_ROW) / MRBE_ROW_STRIDE) + 1;
  localparam int NUM_PHASES     = 7;
  localparam int RAND_ITEMS     = 460;
  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_REPORTS    = 40;

  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic             drivable;
  } pix_item_t;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic               side;
    logic               last_segment;
  } segment_t;

  logic clk;
  logic rst_n;

  mrbe_in_if  in_ch ();
  mrbe_out_if out_ch ();
  mrbe_cfg_if cfg_ch ();

  mask_row_boundary_extractor i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  // predicted block state
  logic [CFG_W-1:0] frame_w;
  logic [CFG_W-1:0] frame_h;
  logic [COL_W-1:0] col_min [NUM_ROWS];
  logic [COL_W-1:0] col_max [NUM_ROWS];
  logic             row_hit [NUM_ROWS];

  pix_item_t pend_q [$];
  segment_t  seg_q [$];
  pix_item_t drv_item;

  int unsigned err_count;
  int unsigned pixels_seen;
  int unsigned frames_seen;
  int unsigned segs_checked;
  int unsigned rand_items;
  int unsigned burst_left;
  int unsigned gap_left;
  int unsigned stall_left;
  int unsigned idle_cycles;
  logic [31:0] cyc;

  always #2 clk = ~clk;

  function automatic logic [ROW_W-1:0] sampled_row(input int unsigned k);
    return ROW_W'(MRBE_MASK_SIZE - 1 - k * MRBE_ROW_STRIDE);
  endfunction

  function automatic logic [COORD_W-1:0] to_frame(input int unsigned pos,
                                                  input logic [CFG_W-1:0] size);
    longint unsigned v;
    v = (longint'(pos) * longint'(size) * 256) / MRBE_MASK_SIZE;
    if (v > COORD_MAX) v = COORD_MAX;
    return v[COORD_W-1:0];
  endfunction

  function automatic pix_item_t mk_item(input logic kind, input logic [ROW_W-1:0] row,
                                        input logic [COL_W-1:0] column, input logic drivable);
    pix_item_t it;
    it.kind     = kind;
    it.row      = row;
    it.column   = column;
    it.drivable = drivable;
    return it;
  endfunction

  function automatic void clear_rows();
    int k;
    for (k = 0; k < NUM_ROWS; k++) begin
      col_min[k] = '1;
      col_max[k] = '0;
      row_hit[k] = 1'b0;
    end
  endfunction

  // fold a pixel into the row store, or turn the store into segments at end of frame
  function automatic void absorb_item(input pix_item_t it);
    int unsigned row_off, k, npts, total, n, i, sd;
    logic [COL_W-1:0] px [2][NUM_ROWS];
    logic [ROW_W-1:0] py [NUM_ROWS];
    segment_t s;
    if (it.kind == KIND_PIXEL) begin
      pixels_seen++;
      if (it.drivable && it.row >= TOP_ROW) begin
        row_off = MRBE_MASK_SIZE - 1 - it.row;
        k = row_off / MRBE_ROW_STRIDE;
        if (row_off % MRBE_ROW_STRIDE == 0 && k < NUM_ROWS) begin
          if (it.column < col_min[k]) col_min[k] = it.column;
          if (it.column > col_max[k]) col_max[k] = it.column;
          row_hit[k] = 1'b1;
        end
      end
    end else begin
      frames_seen++;
      npts = 0;
      for (k = 0; k < NUM_ROWS; k++) begin
        if (row_hit[k] && col_max[k] > col_min[k]) begin
          px[0][npts] = col_min[k];
          px[1][npts] = col_max[k];
          py[npts]    = sampled_row(k);
          npts++;
        end
      end
      total = (npts >= 2) ? 2 * (npts - 1) : 0;
      n = 0;
      for (sd = 0; sd < 2; sd++) begin
        for (i = 0; i + 1 < npts; i++) begin
          s.start_x      = to_frame(px[sd][i], frame_w);
          s.start_y      = to_frame(py[i], frame_h);
          s.end_x        = to_frame(px[sd][i+1], frame_w);
          s.end_y        = to_frame(py[i+1], frame_h);
          s.side         = (sd == 0) ? SIDE_LEFT : SIDE_RIGHT;
          n++;
          s.last_segment = (n == total);
          seg_q = {seg_q, s};
        end
      end
      clear_rows();
    end
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (err_count < MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cyc);
    err_count++;
  endtask

  // random frame: sampled rows with random spans, stray pixels, optional shuffle
  task automatic queue_frame(input bit tidy);
    pix_item_t frame_q [$];
    pix_item_t t;
    int unsigned fill, k, lo, hi, extra, e;
    int i, j;
    fill = tidy ? (($urandom_range(0, 4) == 0) ? 100 : $urandom_range(10, 80)) : 0;
    for (k = 0; k < NUM_ROWS; k++) begin
      if ($urandom_range(1, 100) <= fill) begin
        lo = $urandom_range(0, 255);
        hi = ($urandom_range(0, 9) == 0) ? lo : $urandom_range(lo, 255);
        frame_q = {frame_q, mk_item(KIND_PIXEL, sampled_row(k), COL_W'(lo), 1'b1)};
        frame_q = {frame_q, mk_item(KIND_PIXEL, sampled_row(k), COL_W'(hi), 1'b1)};
        extra = $urandom_range(0, 2);
        for (e = 0; e < extra; e++)
          frame_q = {frame_q, mk_item(KIND_PIXEL, sampled_row(k),
                                      COL_W'($urandom_range(lo, hi)),
                                      1'($urandom_range(0, 1)))};
        rand_items += 2 + extra;
      end
    end
    extra = tidy ? $urandom_range(0, 3) : $urandom_range(4, 12);
    for (e = 0; e < extra; e++)
      frame_q = {frame_q, mk_item(KIND_PIXEL, ROW_W'($urandom_range(0, 255)),
                                  COL_W'($urandom_range(0, 255)),
                                  1'($urandom_range(0, 1)))};
    rand_items += extra;
    if ($urandom_range(0, 2) != 0) begin
      for (i = frame_q.size() - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        t = frame_q[i];
        frame_q[i] = frame_q[j];
        frame_q[j] = t;
      end
    end
    pend_q = {pend_q, frame_q};
    pend_q = {pend_q, mk_item(KIND_EOF, ROW_W'($urandom_range(0, 255)),
                              COL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)))};
    rand_items++;
    // occasional back-to-back end of frame on an empty store
    if ($urandom_range(0, 9) == 0) begin
      pend_q = {pend_q, mk_item(KIND_EOF, ROW_W'($urandom_range(0, 255)),
                                COL_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)))};
      rand_items++;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    if (idx == CFG_FRAME_WIDTH) frame_w = val;
    else frame_h = val;
  endtask

  // hold until all items are taken and all segments are back, then let the block settle
  task automatic drain_and_settle();
    while (pend_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (seg_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // sender: bursts of random length separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.kind     <= KIND_PIXEL;
      in_ch.row      <= '0;
      in_ch.column   <= '0;
      in_ch.drivable <= 1'b0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) absorb_item(drv_item);
      if (gap_left > 0) begin
        gap_left--;
        in_ch.valid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        drv_item = pend_q.pop_front();
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= drv_item.kind;
        in_ch.row      <= drv_item.row;
        in_ch.column   <= drv_item.column;
        in_ch.drivable <= drv_item.drivable;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // receiver: check each segment transaction, stall at random outside quiet windows
  always @(posedge clk) begin
    segment_t want;
    if (!rst_n) begin
      cyc          <= '0;
      out_ch.ready <= 1'b0;
    end else begin
      cyc <= cyc + 32'd1;
      if (out_ch.valid && out_ch.ready) begin
        if (seg_q.size() == 0) begin
          report_mismatch("segment with none expected, start_x", out_ch.start_x, 0);
        end else begin
          want = seg_q.pop_front();
          segs_checked++;
          if (out_ch.start_x !== want.start_x)
            report_mismatch("start_x", out_ch.start_x, want.start_x);
          if (out_ch.start_y !== want.start_y)
            report_mismatch("start_y", out_ch.start_y, want.start_y);
          if (out_ch.end_x !== want.end_x)
            report_mismatch("end_x", out_ch.end_x, want.end_x);
          if (out_ch.end_y !== want.end_y)
            report_mismatch("end_y", out_ch.end_y, want.end_y);
          if (out_ch.side !== want.side)
            report_mismatch("side", out_ch.side, want.side);
          if (out_ch.last_segment !== want.last_segment)
            report_mismatch("last_segment", out_ch.last_segment, want.last_segment);
        end
      end
      if (cyc[10:9] == 2'b11) begin
        stall_left = 0;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if ($urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 12);
      end
    end
  end

  // end the run if no transaction of any kind moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
      $display("mask_row_boundary_extractor verification failed");
      $finish;
    end
  end

  initial begin
    logic [CFG_W-1:0] width_set  [NUM_PHASES];
    logic [CFG_W-1:0] height_set [NUM_PHASES];
    int p;
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_ch.valid   = 1'b0;
    cfg_ch.index   = CFG_FRAME_WIDTH;
    cfg_ch.data    = '0;
    frame_w        = FRAME_W_RST;
    frame_h        = FRAME_H_RST;
    clear_rows();

    width_set  = '{13'd0, 13'h1fff, 13'd1, 13'd4096, 13'd0, 13'd0, FRAME_W_RST};
    height_set = '{13'd0, 13'h1fff, 13'd4096, 13'd1, 13'd0, 13'd0, FRAME_H_RST};
    width_set[4]  = CFG_W'($urandom_range(1, 4096));
    height_set[4] = CFG_W'($urandom_range(1, 4096));
    width_set[5]  = CFG_W'($urandom_range(0, 8191));
    height_set[5] = CFG_W'($urandom_range(0, 8191));

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed frame under reset sizes: column extremes, top sampled row, repeats,
    // single-column row, non-drivable pixels, top quarter and unsampled rows ignored
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd255, 8'd0, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd255, 8'd255, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd71, 8'd200, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd71, 8'd10, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd239, 8'd100, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd239, 8'd100, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd239, 8'd101, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd239, 8'd30, 1'b0)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd247, 8'd50, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd231, 8'd0, 1'b0)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd231, 8'd255, 1'b0)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd63, 8'd5, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd63, 8'd250, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd254, 8'd3, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd254, 8'd9, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_EOF, 8'hff, 8'hff, 1'b1)};
    // empty store, then a single point: neither gives a segment
    pend_q = {pend_q, mk_item(KIND_EOF, 8'h00, 8'h00, 1'b0)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd255, 8'd1, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_PIXEL, 8'd255, 8'd2, 1'b1)};
    pend_q = {pend_q, mk_item(KIND_EOF, 8'h5a, 8'ha5, 1'b1)};
    drain_and_settle();

    for (p = 0; p < NUM_PHASES; p++) begin
      write_reg(CFG_FRAME_WIDTH, width_set[p]);
      write_reg(CFG_FRAME_HEIGHT, height_set[p]);
      rand_items = 0;
      while (rand_items < RAND_ITEMS / NUM_PHASES) queue_frame($urandom_range(0, 7) != 0);
      drain_and_settle();
    end

    $display("ran %0d frames, %0d pixel transactions, %0d segments checked",
             frames_seen, pixels_seen, segs_checked);
    $display("frame sizes swept over %0d settings, zero and saturating among them",
             NUM_PHASES);
    if (err_count == 0 && seg_q.size() == 0) begin
      $display("mask_row_boundary_extractor verification clean");
    end else begin
      $display("mask_row_boundary_extractor verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/mrbe_pkg.sv
rtl/mrbe_if.sv
rtl/mrbe_store.sv
rtl/mrbe_scaler.sv
rtl/mrbe_seq.sv
rtl/mask_row_boundary_extractor.sv
bench/mask_row_boundary_extractor_tb.sv
